// File: rtl/pls_pkg.sv
// Shared types and codes for the positional list store.
package pls_pkg;

  // Request function codes
  localparam logic [2:0] FN_PUSH_FRONT = 3'd0;
  localparam logic [2:0] FN_PUSH_BACK  = 3'd1;
  localparam logic [2:0] FN_INSERT_AT  = 3'd2;
  localparam logic [2:0] FN_POP_FRONT  = 3'd3;
  localparam logic [2:0] FN_POP_BACK   = 3'd4;
  localparam logic [2:0] FN_REMOVE_AT  = 3'd5;
  localparam logic [2:0] FN_DUMP       = 3'd6;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  // Longest dump stream given for one request
  localparam int MAX_RESULTS = 32;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_REMOVE = 2'd2,
    CELL_ROTATE = 2'd3
  } cell_op_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DUMP = 2'b10
  } state_t;

  typedef struct packed {
    logic [2:0]         func;
    logic [5:0]         position;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] element;
    logic               last;
    logic [5:0]         count;
  } rsp_t;

endpackage

// File: rtl/pls_cell.sv
// One storage cell of the list chain: holds, loads, or takes a neighbour's word.
module pls_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int IDX_W      = 5,
  parameter int INDEX      = 0
) (
  input  logic                  clk,
  input  pls_pkg::cell_op_t     op,
  input  logic [IDX_W-1:0]      pos,
  input  logic [IDX_W-1:0]      tail,
  input  logic [DATA_WIDTH-1:0] value,
  input  logic [DATA_WIDTH-1:0] lo_data,
  input  logic [DATA_WIDTH-1:0] hi_data,
  input  logic [DATA_WIDTH-1:0] wrap_data,
  output logic [DATA_WIDTH-1:0] data
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  always_ff @(posedge clk) begin
    unique case (op)
      pls_pkg::CELL_INSERT: begin
        // cells above the slot move up, the slot takes the new word
        if (MY_IDX > pos) begin
          data <= lo_data;
        end else if (MY_IDX == pos) begin
          data <= value;
        end
      end
      pls_pkg::CELL_REMOVE: begin
        if (MY_IDX >= pos) begin
          data <= hi_data;
        end
      end
      pls_pkg::CELL_ROTATE: begin
        // front word wraps round to the tail so the list survives a dump
        if (MY_IDX == tail) begin
          data <= wrap_data;
        end else begin
          data <= hi_data;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: rtl/positional_list_store.sv
// Top level of the positional list store: request decode, control and cell chain.
//
//  channel   dir  handshake            payload
//  request   in   start & !busy        req  (func, position, value)
//  result    out  done, one cycle      rsp  (status, element, last, count)
//
// Every operation but a dump takes one cycle; its result shows on the cycle after
// the request beat, and a new request may be taken on every cycle.
// While a dump of n elements holds busy, the cell chain rotates one word per cycle
// past cell 0 through all n words; only the first 32 words each give a result.
// A dump of an empty list gives a single ST_EMPTY result and does not raise busy.
// Synchronous reset empties the list; cell contents are not cleared.
// The receiver cannot stall: each result is valid for its one done cycle only.
module positional_list_store #(
  parameter int CAPACITY   = 32,
  parameter int DATA_WIDTH = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  pls_pkg::req_t   req,
  output logic            busy,
  output logic            done,
  output pls_pkg::rsp_t   rsp
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int OCC_W = $clog2(CAPACITY + 1);
  localparam int PW    = (OCC_W > 6) ? OCC_W : 6;

  pls_pkg::state_t   state, state_next;
  logic [OCC_W-1:0]  occ, occ_next;
  logic [IDX_W-1:0]  step, step_next;

  pls_pkg::cell_op_t cell_op;
  logic [IDX_W-1:0]  cell_pos;
  logic [IDX_W-1:0]  cell_tail;
  logic [DATA_WIDTH-1:0] store_value;
  logic [DATA_WIDTH-1:0] cell_q [CAPACITY];

  logic              accept;
  logic              emit;
  logic [1:0]        status;
  logic              is_dump;
  logic              dump_last;
  logic [PW-1:0]     ins_pos;
  logic [PW-1:0]     occ_w;
  logic [PW-1:0]     req_pos;

  assign busy        = (state == pls_pkg::S_DUMP);
  assign accept      = start && !busy;
  assign occ_w       = PW'(occ);
  assign req_pos     = PW'(req.position);
  assign cell_tail   = IDX_W'(occ - OCC_W'(1));
  assign store_value = DATA_WIDTH'(64'($unsigned(req.value)));
  assign dump_last   = (int'(step) + 1 ==
                        ((int'(occ) < pls_pkg::MAX_RESULTS) ? int'(occ)
                                                           : pls_pkg::MAX_RESULTS));

  always_comb begin
    state_next = state;
    occ_next   = occ;
    step_next  = step;
    cell_op    = pls_pkg::CELL_HOLD;
    cell_pos   = '0;
    emit       = 1'b0;
    status     = pls_pkg::ST_OK;
    is_dump    = 1'b0;
    ins_pos    = '0;
    unique case (state)
      pls_pkg::S_IDLE: begin
        if (accept) begin
          unique case (req.func) inside
            pls_pkg::FN_PUSH_FRONT, pls_pkg::FN_PUSH_BACK, pls_pkg::FN_INSERT_AT: begin
              if (req.func == pls_pkg::FN_PUSH_BACK) begin
                ins_pos = occ_w;
              end else if (req.func == pls_pkg::FN_INSERT_AT) begin
                ins_pos = req_pos;
              end
              emit = 1'b1;
              // full is checked ahead of the position
              if (int'(occ) == CAPACITY) begin
                status = pls_pkg::ST_FULL;
              end else if (ins_pos > occ_w) begin
                status = pls_pkg::ST_INVALID;
              end else begin
                cell_op  = pls_pkg::CELL_INSERT;
                cell_pos = IDX_W'(ins_pos);
                occ_next = occ + OCC_W'(1);
              end
            end
            pls_pkg::FN_POP_FRONT, pls_pkg::FN_POP_BACK: begin
              emit = 1'b1;
              if (occ == '0) begin
                status = pls_pkg::ST_EMPTY;
              end else begin
                // popping the back only shortens the list
                if (req.func == pls_pkg::FN_POP_FRONT) begin
                  cell_op = pls_pkg::CELL_REMOVE;
                end
                occ_next = occ - OCC_W'(1);
              end
            end
            pls_pkg::FN_REMOVE_AT: begin
              emit = 1'b1;
              if (req_pos >= occ_w) begin
                status = pls_pkg::ST_INVALID;
              end else begin
                cell_op  = pls_pkg::CELL_REMOVE;
                cell_pos = IDX_W'(req_pos);
                occ_next = occ - OCC_W'(1);
              end
            end
            pls_pkg::FN_DUMP: begin
              if (occ == '0) begin
                emit   = 1'b1;
                status = pls_pkg::ST_EMPTY;
              end else begin
                step_next  = '0;
                state_next = pls_pkg::S_DUMP;
              end
            end
            default: begin
            end
          endcase
        end
      end
      pls_pkg::S_DUMP: begin
        cell_op = pls_pkg::CELL_ROTATE;
        is_dump = 1'b1;
        emit    = (int'(step) < pls_pkg::MAX_RESULTS);
        // keep rotating past the stream limit so the order comes back intact
        if (int'(step) + 1 == int'(occ)) begin
          state_next = pls_pkg::S_IDLE;
        end else begin
          step_next = step + IDX_W'(1);
        end
      end
      default: begin
        state_next = pls_pkg::S_IDLE;
      end
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] lo_d, hi_d;
    if (i == 0) begin : g_lo_end
      assign lo_d = store_value;
    end else begin : g_lo
      assign lo_d = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_hi_end
      assign hi_d = cell_q[i];
    end else begin : g_hi
      assign hi_d = cell_q[i+1];
    end
    pls_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .IDX_W      (IDX_W),
      .INDEX      (i)
    ) u_cell (
      .clk       (clk),
      .op        (cell_op),
      .pos       (cell_pos),
      .tail      (cell_tail),
      .value     (store_value),
      .lo_data   (lo_d),
      .hi_data   (hi_d),
      .wrap_data (cell_q[0]),
      .data      (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pls_pkg::S_IDLE;
      occ   <= '0;
      step  <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      occ   <= occ_next;
      step  <= step_next;
      done  <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      rsp.status  <= status;
      rsp.element <= is_dump ? $signed(32'(64'(cell_q[0]))) : '0;
      rsp.last    <= is_dump ? dump_last : 1'b1;
      rsp.count   <= 6'(occ_next);
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    int'(occ) <= CAPACITY)
    else $error("occupancy beyond capacity");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    done && rsp.status == pls_pkg::ST_FULL |-> rsp.count == 6'(CAPACITY))
    else $error("full status with list not full");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    done && rsp.status == pls_pkg::ST_EMPTY |-> rsp.count == '0 && rsp.last)
    else $error("empty status with elements held");

  a_stream_gapless: assert property (@(posedge clk) disable iff (rst)
    done && !rsp.last |=> done && rsp.status == pls_pkg::ST_OK)
    else $error("dump stream broken");

endmodule
